/* rtl/core/fbpa_pkg.sv */
// fbpa_pkg: shared types, codes and reset values of the fixed block pool allocator
// depends on nothing; used by fbpa_ctrl, fbpa_dp, fixed_block_pool_allocator and fbpa_checker
package fbpa_pkg;

  localparam int ADDR_W         = 48;
  localparam int COUNTER_BITS   = 32;
  localparam int STRIDE_W       = 21;
  localparam int COUNT_W        = 11;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 48;
  localparam int MAX_BLOCKS_DEF = 1024;

  // operations
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNDEF   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNAVAILABLE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOREIGN     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INTERIOR    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DOUBLE      = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd3;

  // configuration reset values
  localparam logic                RST_ENABLE = 1'b1;
  localparam logic [ADDR_W-1:0]   RST_BASE   = 48'h0000_0001_0000;
  localparam logic [STRIDE_W-1:0] RST_STRIDE = 21'd64;
  localparam logic [COUNT_W-1:0]  RST_COUNT  = 11'd1024;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [ADDR_W-1:0]       block_address;
    logic [COUNT_W-1:0]      blocks_in_use;
    logic [COUNT_W-1:0]      blocks_in_use_peak;
    logic [COUNTER_BITS-1:0] good_allocations;
    logic [COUNTER_BITS-1:0] good_releases;
    logic [COUNTER_BITS-1:0] alloc_failures;
    logic [COUNTER_BITS-1:0] bad_releases;
    logic [COUNTER_BITS-1:0] reset_events;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                rd_head;
    logic                alloc_commit;
    logic                alloc_fail;
    logic                rel_prep;
    logic                div_start;
    logic                div_step;
    logic                rd_quo;
    logic                rel_commit;
    logic                bad_release;
    logic                walk_start;
    logic                walk_step;
    logic                reset_evt;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            enabled;
    logic [OP_W-1:0] op;
    logic            head_valid;
    logic            is_null;
    logic            below_base;
    logic            beyond_span;
    logic            div_last;
    logic            rem_zero;
    logic            entry_in_use;
    logic            walk_last;
    logic            out_free;
  } sts_t;

endpackage

/* rtl/core/fbpa_ram.sv */
// fbpa_ram: generic single-port ram, registered read
// depends on nothing
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/fbpa_ctrl.sv */
// fbpa_ctrl: sequencing state machine of the block pool allocator
// depends on fbpa_pkg
module fbpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fbpa_pkg::sts_t sts,
  output fbpa_pkg::cmd_t cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_ALLOC  = 4'd3;
  localparam logic [3:0] S_RCHK   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_RIDX   = 4'd6;
  localparam logic [3:0] S_RUSE   = 4'd7;
  localparam logic [3:0] S_WALK   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.enabled) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = fbpa_pkg::ST_UNAVAILABLE;
          state_nxt       = S_DONE;
        end else begin
          case (sts.op)
            fbpa_pkg::OP_ALLOC: begin
              if (sts.head_valid) begin
                cmd.rd_head = 1'b1;
                state_nxt   = S_ALLOC;
              end else begin
                cmd.alloc_fail  = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = fbpa_pkg::ST_EXHAUSTED;
                state_nxt       = S_DONE;
              end
            end
            fbpa_pkg::OP_RELEASE: begin
              cmd.rel_prep = 1'b1;
              state_nxt    = S_RCHK;
            end
            fbpa_pkg::OP_RESET: begin
              cmd.walk_start = 1'b1;
              state_nxt      = S_WALK;
            end
            default: begin
              cmd.set_status  = 1'b1;
              cmd.status_code = fbpa_pkg::ST_UNAVAILABLE;
              state_nxt       = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        cmd.alloc_commit = 1'b1;
        cmd.set_status   = 1'b1;
        cmd.status_code  = fbpa_pkg::ST_OK;
        state_nxt        = S_DONE;
      end
      S_RCHK: begin
        if (sts.is_null) begin
          cmd.bad_release = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = fbpa_pkg::ST_NULL;
          state_nxt       = S_DONE;
        end else if (sts.below_base || sts.beyond_span) begin
          cmd.bad_release = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = fbpa_pkg::ST_FOREIGN;
          state_nxt       = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_RIDX;
      end
      S_RIDX: begin
        if (!sts.rem_zero) begin
          cmd.bad_release = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = fbpa_pkg::ST_INTERIOR;
          state_nxt       = S_DONE;
        end else begin
          cmd.rd_quo = 1'b1;
          state_nxt  = S_RUSE;
        end
      end
      S_RUSE: begin
        cmd.set_status = 1'b1;
        if (!sts.entry_in_use) begin
          cmd.bad_release = 1'b1;
          cmd.status_code = fbpa_pkg::ST_DOUBLE;
        end else begin
          cmd.rel_commit  = 1'b1;
          cmd.status_code = fbpa_pkg::ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          cmd.reset_evt   = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = fbpa_pkg::ST_OK;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/fbpa_dp.sv */
// fbpa_dp: configuration, free list ram, counters, divider and output register
// depends on fbpa_pkg and fbpa_ram
module fbpa_dp #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  fbpa_pkg::in_item_t                 in_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output fbpa_pkg::out_item_t                out_data,
  input  fbpa_pkg::cmd_t                     cmd,
  output fbpa_pkg::sts_t                     sts
);

  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int SW  = fbpa_pkg::STRIDE_W;
  localparam int AW  = fbpa_pkg::ADDR_W;
  localparam int NB  = fbpa_pkg::COUNTER_BITS;
  localparam int PW  = IW + SW;
  localparam int SPW = SW + CW;
  localparam int OFW = (AW > SPW) ? AW : SPW;
  localparam int DVW = SW + IW;
  localparam int KW  = (IW > 1) ? $clog2(IW) : 1;
  localparam int RW  = IW + 2;
  localparam int EW  = IW + 1;

  function automatic logic [CW-1:0] clamp_count(input logic [fbpa_pkg::COUNT_W-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (int'(c) > MAX_BLOCKS) begin
      r = CW'(MAX_BLOCKS);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  // configuration
  logic                           en_r;
  logic [AW-1:0]                  base_r;
  logic [SW-1:0]                  stride_r;
  logic [fbpa_pkg::COUNT_W-1:0]   count_r;
  logic [SW-1:0]                  eff_stride;

  // item and pool state
  logic [fbpa_pkg::OP_W-1:0]      op_r;
  logic [AW-1:0]                  addr_r;
  logic [IW-1:0]                  head_r;
  logic                           hv_r;
  logic [CW-1:0]                  live_r, peak_r, active_r;
  logic [NB-1:0]                  aok_r, rok_r, afail_r, rbad_r, revt_r;
  logic [IW-1:0]                  walk_r;

  // arithmetic
  logic [PW-1:0]                  prod_r;
  logic [SPW-1:0]                 span_r;
  logic [OFW-1:0]                 off_r;
  logic                           null_r, below_r;
  logic [SPW-1:0]                 rem_r;
  logic [DVW-1:0]                 dvs_r;
  logic [IW-1:0]                  quo_r;
  logic [KW-1:0]                  kc_r;
  logic                           ge;

  // result
  logic [fbpa_pkg::STATUS_W-1:0]  status_r;
  logic [AW-1:0]                  blk_r;
  logic                           out_valid_r;
  fbpa_pkg::out_item_t            out_r;

  // ram
  logic                           ram_we;
  logic [IW-1:0]                  ram_addr;
  logic [RW-1:0]                  ram_wdata, ram_rdata;
  logic                           walk_lv;
  logic                           walk_last;

  assign eff_stride = (stride_r == '0) ? SW'(1) : stride_r;
  assign walk_last  = (walk_r == IW'(MAX_BLOCKS - 1));
  assign walk_lv    = ({1'b0, walk_r} + EW'(1)) < EW'(active_r);
  assign ge         = rem_r >= SPW'(dvs_r);

  always_comb begin
    ram_we = cmd.walk_step | cmd.alloc_commit | cmd.rel_commit;
    if (cmd.walk_step) begin
      ram_addr = walk_r;
    end else if (cmd.rd_quo || cmd.rel_commit) begin
      ram_addr = quo_r;
    end else begin
      ram_addr = head_r;
    end
    if (cmd.walk_step) begin
      ram_wdata = {1'b0, walk_lv, walk_lv ? IW'(walk_r + IW'(1)) : IW'(0)};
    end else if (cmd.alloc_commit) begin
      ram_wdata = {1'b1, ram_rdata[IW], ram_rdata[IW-1:0]};
    end else begin
      ram_wdata = {1'b0, hv_r, head_r};
    end
  end

  fbpa_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_BLOCKS)
  ) u_fbpa_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.enabled      = en_r;
    sts.op           = op_r;
    sts.head_valid   = hv_r;
    sts.is_null      = null_r;
    sts.below_base   = below_r;
    sts.beyond_span  = off_r >= OFW'(span_r);
    sts.div_last     = (kc_r == '0);
    sts.rem_zero     = (rem_r == '0);
    sts.entry_in_use = ram_rdata[IW+1];
    sts.walk_last    = walk_last;
    sts.out_free     = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= fbpa_pkg::RST_ENABLE;
      base_r      <= fbpa_pkg::RST_BASE;
      stride_r    <= fbpa_pkg::RST_STRIDE;
      count_r     <= fbpa_pkg::RST_COUNT;
      head_r      <= '0;
      hv_r        <= 1'b1;
      live_r      <= '0;
      peak_r      <= '0;
      active_r    <= clamp_count(fbpa_pkg::RST_COUNT);
      aok_r       <= '0;
      rok_r       <= '0;
      afail_r     <= '0;
      rbad_r      <= '0;
      revt_r      <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fbpa_pkg::CFG_ENABLE: en_r     <= cfg_wdata[0];
          fbpa_pkg::CFG_BASE:   base_r   <= AW'(cfg_wdata);
          fbpa_pkg::CFG_STRIDE: stride_r <= cfg_wdata[SW-1:0];
          fbpa_pkg::CFG_COUNT:  count_r  <= cfg_wdata[fbpa_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.walk_start) begin
        walk_r   <= '0;
        active_r <= clamp_count(count_r);
      end
      if (cmd.walk_step) begin
        walk_r <= walk_r + IW'(1);
        if (walk_last) begin
          head_r <= '0;
          hv_r   <= 1'b1;
          live_r <= '0;
        end
      end
      if (cmd.alloc_commit) begin
        head_r <= ram_rdata[IW-1:0];
        hv_r   <= ram_rdata[IW];
        live_r <= live_r + CW'(1);
        if (live_r + CW'(1) > peak_r) peak_r <= live_r + CW'(1);
        if (aok_r != '1) aok_r <= aok_r + NB'(1);
      end
      if (cmd.rel_commit) begin
        head_r <= quo_r;
        hv_r   <= 1'b1;
        if (live_r != '0) live_r <= live_r - CW'(1);
        if (rok_r != '1) rok_r <= rok_r + NB'(1);
      end
      if (cmd.alloc_fail && afail_r != '1) afail_r <= afail_r + NB'(1);
      if (cmd.bad_release && rbad_r != '1) rbad_r <= rbad_r + NB'(1);
      if (cmd.reset_evt && revt_r != '1) revt_r <= revt_r + NB'(1);
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_data.operation;
      addr_r <= in_data.address;
      blk_r  <= '0;
    end
    if (cmd.rd_head) begin
      prod_r <= PW'(head_r) * PW'(eff_stride);
    end
    if (cmd.alloc_commit) begin
      blk_r <= base_r + AW'(prod_r);
    end
    if (cmd.rel_prep) begin
      null_r  <= (addr_r == '0);
      below_r <= (addr_r < base_r);
      off_r   <= OFW'(addr_r - base_r);
      span_r  <= SPW'(eff_stride) * SPW'(active_r);
    end
    if (cmd.div_start) begin
      rem_r <= SPW'(off_r);
      dvs_r <= DVW'(eff_stride) << (IW - 1);
      quo_r <= '0;
      kc_r  <= KW'(IW - 1);
    end
    if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - SPW'(dvs_r);
      dvs_r <= dvs_r >> 1;
      quo_r <= IW'({quo_r, ge});
      kc_r  <= kc_r - KW'(1);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.load_out) begin
      out_r.status             <= status_r;
      out_r.block_address      <= blk_r;
      out_r.blocks_in_use      <= fbpa_pkg::COUNT_W'(live_r);
      out_r.blocks_in_use_peak <= fbpa_pkg::COUNT_W'(peak_r);
      out_r.good_allocations   <= aok_r;
      out_r.good_releases      <= rok_r;
      out_r.alloc_failures     <= afail_r;
      out_r.bad_releases       <= rbad_r;
      out_r.reset_events       <= revt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/fixed_block_pool_allocator.sv */
// fixed_block_pool_allocator: top level, fixed-size block allocator over a lifo free list
// depends on fbpa_pkg, fbpa_ctrl, fbpa_dp (and fbpa_ram below it)
// one item at a time: allocate pops the free list head; release checks the address, then
// divides by the stride (one quotient bit per cycle); pool reset walks the ram; unavailable,
// exhausted, null, foreign and interior end early; in_ready returns with out_valid if out is free
// after rst_n the ram is rebuilt over all MAX_BLOCKS entries with in_ready low; config taken anytime
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // operation items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fbpa_pkg::in_item_t              in_data,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output fbpa_pkg::out_item_t             out_data
);

  // command and status between sequencer and datapath
  fbpa_pkg::cmd_t cmd;
  fbpa_pkg::sts_t sts;

  // sequencer: walks the ram after reset, then runs one item through
  // decode, ram access, divider steps and the result hand-off
  fbpa_ctrl u_fbpa_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: config registers, free list ram with in-use and link bits,
  // span multiply, restoring divider, saturating counters, result register
  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_fbpa_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/core/fbpa_checker.sv */
// fbpa_checker: port-level assertions for the block pool allocator, bound to the top level
// depends on fbpa_pkg and fixed_block_pool_allocator
module fbpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fbpa_pkg::out_item_t out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // block address only on a good item
  a_blk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fbpa_pkg::ST_OK |-> out_data.block_address == '0)
    else $error("block address on failed item");

  // live never above peak
  a_live_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.blocks_in_use <= out_data.blocks_in_use_peak)
    else $error("live count above peak");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
